FILE: hw/rtl/hlgp_pkg.sv
// ----------------------------------------------------------------------------
// hlgp_pkg
// Shared widths, limits, register indexes and the point sideband record for
// the Hough line ground projection pipeline.
// ----------------------------------------------------------------------------
package hlgp_pkg;

    localparam int OUT_W  = 20;
    localparam int UV_W   = 21;
    localparam int TRIG_W = 16;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 20'sh7FFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 20'sh80000;

    localparam logic [2:0] CFG_HALF_WIDTH    = 3'd0;
    localparam logic [2:0] CFG_HALF_HEIGHT   = 3'd1;
    localparam logic [2:0] CFG_FOCAL_LENGTH  = 3'd2;
    localparam logic [2:0] CFG_CAMERA_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_GROUND_OFFSET = 3'd4;
    localparam logic [2:0] CFG_SIN_TILT      = 3'd5;
    localparam logic [2:0] CFG_COS_TILT      = 3'd6;

    typedef struct packed {
        logic                    second;
        logic                    deg;
        logic                    sat;
        logic signed [UV_W-1:0]  u;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
    } pt_side_t;

endpackage

FILE: hw/rtl/hlgp_cordic.sv
// ----------------------------------------------------------------------------
// hlgp_cordic
// Pipelined 16-step rotation CORDIC giving sine and cosine of a Q2.13 angle
// in Q1.14, with reduction by pi and a sideband that travels alongside.
// ----------------------------------------------------------------------------
module hlgp_cordic #(
    parameter int SIDE_W = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic signed [15:0]                   angle,
    input  logic [SIDE_W-1:0]                    in_side,
    output logic                                 out_valid,
    output logic signed [hlgp_pkg::TRIG_W-1:0]   sin_val,
    output logic signed [hlgp_pkg::TRIG_W-1:0]   cos_val,
    output logic [SIDE_W-1:0]                    out_side
);

    localparam int CW    = 24;
    localparam int STEPS = 16;
    localparam int TW    = hlgp_pkg::TRIG_W;
    localparam logic signed [16:0]   PI_Q13      = 17'sd25736;
    localparam logic signed [16:0]   HALF_PI_Q13 = 17'sd12868;
    localparam logic signed [CW-1:0] GAIN        = 24'sd636751;
    localparam logic signed [CW-1:0] ATAN_Q20 [STEPS] = '{
        24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396,
        24'sd65451,  24'sd32757,  24'sd16383,  24'sd8192,
        24'sd4096,   24'sd2048,   24'sd1024,   24'sd512,
        24'sd256,    24'sd128,    24'sd64,     24'sd32
    };

    logic signed [CW-1:0] x_reg [0:STEPS];
    logic signed [CW-1:0] y_reg [0:STEPS];
    logic signed [CW-1:0] z_reg [0:STEPS];
    logic                 neg_reg [0:STEPS];
    logic [SIDE_W-1:0]    side_reg [0:STEPS];
    logic                 valid_reg [0:STEPS];

    logic signed [16:0] th_ext;
    logic signed [16:0] th_red;
    logic               neg_next;

    always_comb
    begin
        th_ext   = 17'(angle);
        th_red   = th_ext;
        neg_next = 1'b0;
        if (th_ext > HALF_PI_Q13)
        begin
            th_red   = th_ext - PI_Q13;
            neg_next = 1'b1;
        end
        else if (th_ext < -HALF_PI_Q13)
        begin
            th_red   = th_ext + PI_Q13;
            neg_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= GAIN;
        y_reg[0]    <= '0;
        z_reg[0]    <= {th_red, 7'd0};
        neg_reg[0]  <= neg_next;
        side_reg[0] <= in_side;
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        logic signed [CW-1:0] x_next;
        logic signed [CW-1:0] y_next;
        logic signed [CW-1:0] z_next;

        always_comb
        begin
            if (!z_reg[i][CW-1])
            begin
                x_next = x_reg[i] - (y_reg[i] >>> i);
                y_next = y_reg[i] + (x_reg[i] >>> i);
                z_next = z_reg[i] - ATAN_Q20[i];
            end
            else
            begin
                x_next = x_reg[i] + (y_reg[i] >>> i);
                y_next = y_reg[i] - (x_reg[i] >>> i);
                z_next = z_reg[i] + ATAN_Q20[i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i+1] <= 1'b0;
            else
                valid_reg[i+1] <= valid_reg[i];
        end

        always_ff @(posedge clk)
        begin
            x_reg[i+1]    <= x_next;
            y_reg[i+1]    <= y_next;
            z_reg[i+1]    <= z_next;
            neg_reg[i+1]  <= neg_reg[i];
            side_reg[i+1] <= side_reg[i];
        end
    end

    function automatic logic signed [TW-1:0] trig_round(
        input logic signed [CW-1:0] v,
        input logic                 neg
    );
        logic signed [CW:0]   r;
        logic signed [CW-6:0] s;
        logic signed [TW-1:0] c;
        r = (CW+1)'(v) + (CW+1)'(32);
        s = r[CW:6];
        if (s > (CW-5)'(16384))
            c = TW'(16384);
        else if (s < -((CW-5)'(16384)))
            c = -TW'(16384);
        else
            c = s[TW-1:0];
        if (neg)
            c = -c;
        return c;
    endfunction

    logic                 out_valid_reg;
    logic signed [TW-1:0] sin_reg;
    logic signed [TW-1:0] cos_reg;
    logic [SIDE_W-1:0]    out_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= valid_reg[STEPS];
    end

    always_ff @(posedge clk)
    begin
        cos_reg      <= trig_round(x_reg[STEPS], neg_reg[STEPS]);
        sin_reg      <= trig_round(y_reg[STEPS], neg_reg[STEPS]);
        out_side_reg <= side_reg[STEPS];
    end

    assign out_valid = out_valid_reg;
    assign sin_val   = sin_reg;
    assign cos_val   = cos_reg;
    assign out_side  = out_side_reg;

endmodule

FILE: hw/rtl/hlgp_div.sv
// ----------------------------------------------------------------------------
// hlgp_div
// Pipelined restoring divider, one quotient bit per stage. Signed numerator,
// positive denominator, quotient truncated toward zero and clipped to the
// output range with a saturation flag.
// ----------------------------------------------------------------------------
module hlgp_div #(
    parameter int NUM_W  = 51,
    parameter int DEN_W  = 37,
    parameter int SIDE_W = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic signed [NUM_W-1:0]             num,
    input  logic [DEN_W-1:0]                    den,
    input  logic [SIDE_W-1:0]                   in_side,
    output logic                                out_valid,
    output logic signed [hlgp_pkg::OUT_W-1:0]   quot,
    output logic                                sat,
    output logic [SIDE_W-1:0]                   out_side
);

    localparam int OW = hlgp_pkg::OUT_W;
    localparam int QB = OW + 1;
    localparam int W  = (NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB;
    localparam logic [QB-1:0] POS_LIM = {1'b0, hlgp_pkg::OUT_MAX};
    localparam logic [QB-1:0] NEG_LIM = POS_LIM + QB'(1);

    logic              a_valid_reg;
    logic [NUM_W-1:0]  a_mag_reg;
    logic              a_neg_reg;
    logic [DEN_W-1:0]  a_den_reg;
    logic [SIDE_W-1:0] a_side_reg;
    logic [NUM_W-1:0]  a_mag_next;

    assign a_mag_next = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        a_mag_reg  <= a_mag_next;
        a_neg_reg  <= num[NUM_W-1];
        a_den_reg  <= den;
        a_side_reg <= in_side;
    end

    logic [W-1:0]      rem_reg  [0:QB];
    logic [QB-1:0]     q_reg    [0:QB];
    logic [DEN_W-1:0]  den_reg  [0:QB];
    logic              neg_reg  [0:QB];
    logic              ovf_reg  [0:QB];
    logic [SIDE_W-1:0] side_reg [0:QB];
    logic              valid_reg [0:QB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else
            valid_reg[0] <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= W'(a_mag_reg);
        q_reg[0]    <= '0;
        den_reg[0]  <= a_den_reg;
        neg_reg[0]  <= a_neg_reg;
        ovf_reg[0]  <= W'(a_mag_reg) >= (W'(a_den_reg) << QB);
        side_reg[0] <= a_side_reg;
    end

    for (genvar j = 0; j < QB; j++)
    begin : g_bit
        localparam int B = QB - 1 - j;
        logic [W:0]    trial;
        logic [W-1:0]  rem_next;
        logic [QB-1:0] q_next;

        always_comb
        begin
            trial    = {1'b0, rem_reg[j]} - {1'b0, W'(den_reg[j]) << B};
            rem_next = rem_reg[j];
            q_next   = q_reg[j];
            if (!trial[W])
            begin
                rem_next  = trial[W-1:0];
                q_next[B] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[j+1] <= 1'b0;
            else
                valid_reg[j+1] <= valid_reg[j];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j+1]  <= rem_next;
            q_reg[j+1]    <= q_next;
            den_reg[j+1]  <= den_reg[j];
            neg_reg[j+1]  <= neg_reg[j];
            ovf_reg[j+1]  <= ovf_reg[j];
            side_reg[j+1] <= side_reg[j];
        end
    end

    logic                 quot_next;
    logic signed [OW-1:0] val_next;
    logic                 sat_next;
    logic [QB-1:0]        mag;

    always_comb
    begin
        mag      = q_reg[QB];
        sat_next = 1'b0;
        if (ovf_reg[QB])
        begin
            sat_next = 1'b1;
            val_next = neg_reg[QB] ? hlgp_pkg::OUT_MIN : hlgp_pkg::OUT_MAX;
        end
        else if (!neg_reg[QB])
        begin
            if (mag > POS_LIM)
            begin
                sat_next = 1'b1;
                val_next = hlgp_pkg::OUT_MAX;
            end
            else
                val_next = mag[OW-1:0];
        end
        else
        begin
            if (mag > NEG_LIM)
            begin
                sat_next = 1'b1;
                val_next = hlgp_pkg::OUT_MIN;
            end
            else
                val_next = -(mag[OW-1:0]);
        end
        quot_next = valid_reg[QB];
    end

    logic                 out_valid_reg;
    logic signed [OW-1:0] quot_reg;
    logic                 sat_reg;
    logic [SIDE_W-1:0]    out_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= quot_next;
    end

    always_ff @(posedge clk)
    begin
        quot_reg     <= val_next;
        sat_reg      <= sat_next;
        out_side_reg <= side_reg[QB];
    end

    assign out_valid = out_valid_reg;
    assign quot      = quot_reg;
    assign sat       = sat_reg;
    assign out_side  = out_side_reg;

endmodule

FILE: hw/rtl/hough_line_ground_projection_unit.sv
// ----------------------------------------------------------------------------
// hough_line_ground_projection_unit
// Projects the two end points of a Hough line onto the ground plane of a
// tilted camera and emits them as two ground points.
//
// Input: a line is taken at a rising edge with start high and busy low.
// busy rises for the cycle after each transfer, so a new line is never taken
// while busy is high: the two points of a line share one point pipeline
// that takes a point each cycle.
// Output: result_valid strobes for one cycle per point; the second point,
// marked by second_point, appears in the cycle after the first. The depth
// comes from the 16-step CORDIC and three dividers of 21 quotient-bit
// stages. The receiver cannot stall; results are never held.
// Configuration: cfg_ready is always high; write registers only while idle.
// Reset clears the pipeline valid bits and loads the default registers.
// ----------------------------------------------------------------------------
module hough_line_ground_projection_unit #(
    parameter int SEGMENT_HALF_LENGTH = 200
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] line_distance,
    input  logic signed [15:0] line_angle,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output logic               result_valid,
    output logic signed [19:0] ground_x,
    output logic signed [19:0] ground_y,
    output logic               second_point,
    output logic               saturated
);

    localparam int OW     = hlgp_pkg::OUT_W;
    localparam int UW     = hlgp_pkg::UV_W;
    localparam int TW     = hlgp_pkg::TRIG_W;
    localparam int SUM_W  = 35;
    localparam int D_W    = 38;
    localparam int VH_W   = 37;
    localparam int N1_W   = VH_W + 14;
    localparam int N2_W   = 36;
    localparam int N3_W   = UW + OW;
    localparam int P_W    = 36;
    localparam int G_W    = 38;
    localparam int SIDE_W = $bits(hlgp_pkg::pt_side_t);
    localparam logic signed [16:0] SEG_L16 = 17'(SEGMENT_HALF_LENGTH * 16);

    // configuration registers
    logic [11:0]        half_width_reg;
    logic [11:0]        half_height_reg;
    logic [15:0]        focal_reg;
    logic [14:0]        height_reg;
    logic signed [15:0] offset_reg;
    logic signed [15:0] sin_reg;
    logic [14:0]        cos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg  <= 12'd320;
            half_height_reg <= 12'd240;
            focal_reg       <= 16'd5120;
            height_reg      <= 15'd1638;
            offset_reg      <= 16'sd1434;
            sin_reg         <= 16'sd6924;
            cos_reg         <= 15'd14849;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                hlgp_pkg::CFG_HALF_WIDTH:    half_width_reg  <= cfg_data[11:0];
                hlgp_pkg::CFG_HALF_HEIGHT:   half_height_reg <= cfg_data[11:0];
                hlgp_pkg::CFG_FOCAL_LENGTH:  focal_reg       <= cfg_data;
                hlgp_pkg::CFG_CAMERA_HEIGHT: height_reg      <= cfg_data[14:0];
                hlgp_pkg::CFG_GROUND_OFFSET: offset_reg      <= cfg_data;
                hlgp_pkg::CFG_SIN_TILT:      sin_reg         <= cfg_data;
                hlgp_pkg::CFG_COS_TILT:      cos_reg         <= cfg_data[14:0];
                default:                     ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // input transfer, no new line while busy is high
    logic accept;
    logic busy_reg;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= accept;
    end

    // sine and cosine of the line angle
    logic                 cs_valid;
    logic signed [TW-1:0] sin_w;
    logic signed [TW-1:0] cos_w;
    logic [15:0]          rho_bits;
    logic signed [15:0]   rho_w;

    hlgp_cordic #(
        .SIDE_W (16)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .angle     (line_angle),
        .in_side   (line_distance),
        .out_valid (cs_valid),
        .sin_val   (sin_w),
        .cos_val   (cos_w),
        .out_side  (rho_bits)
    );

    assign rho_w = rho_bits;

    // foot point and segment offsets
    logic               m_valid_reg;
    logic signed [31:0] m_x0_reg;
    logic signed [31:0] m_y0_reg;
    logic signed [32:0] m_ls_reg;
    logic signed [32:0] m_lc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= cs_valid;
    end

    always_ff @(posedge clk)
    begin
        m_x0_reg <= 32'(cos_w) * 32'(rho_w);
        m_y0_reg <= 32'(sin_w) * 32'(rho_w);
        m_ls_reg <= 33'(sin_w) * 33'(SEG_L16);
        m_lc_reg <= 33'(cos_w) * 33'(SEG_L16);
    end

    // centred point coordinates
    logic signed [SUM_W-1:0] cu;
    logic signed [SUM_W-1:0] cv;
    logic signed [SUM_W-1:0] u1_sum;
    logic signed [SUM_W-1:0] v1_sum;
    logic signed [SUM_W-1:0] u2_sum;
    logic signed [SUM_W-1:0] v2_sum;

    always_comb
    begin
        cu     = $signed(SUM_W'({half_width_reg, 18'd0}));
        cv     = $signed(SUM_W'({half_height_reg, 18'd0}));
        u1_sum = SUM_W'(m_x0_reg) - SUM_W'(m_ls_reg) - cu + SUM_W'(8192);
        v1_sum = SUM_W'(m_y0_reg) + SUM_W'(m_lc_reg) - cv + SUM_W'(8192);
        u2_sum = SUM_W'(m_x0_reg) + SUM_W'(m_ls_reg) - cu + SUM_W'(8192);
        v2_sum = SUM_W'(m_y0_reg) - SUM_W'(m_lc_reg) - cv + SUM_W'(8192);
    end

    logic                 p_valid_reg;
    logic signed [UW-1:0] p_u1_reg;
    logic signed [UW-1:0] p_v1_reg;
    logic signed [UW-1:0] p_u2_reg;
    logic signed [UW-1:0] p_v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else
            p_valid_reg <= m_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (m_valid_reg)
        begin
            p_u1_reg <= u1_sum[SUM_W-1:14];
            p_v1_reg <= v1_sum[SUM_W-1:14];
            p_u2_reg <= u2_sum[SUM_W-1:14];
            p_v2_reg <= v2_sum[SUM_W-1:14];
        end
    end

    // issue first point, then second point in the next cycle
    logic                 hold_reg;
    logic                 s_valid_reg;
    logic                 s_second_reg;
    logic signed [UW-1:0] s_u_reg;
    logic signed [UW-1:0] s_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg    <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else
        begin
            hold_reg    <= p_valid_reg;
            s_valid_reg <= p_valid_reg || hold_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s_second_reg <= !p_valid_reg;
        s_u_reg      <= p_valid_reg ? p_u1_reg : p_u2_reg;
        s_v_reg      <= p_valid_reg ? p_v1_reg : p_v2_reg;
    end

    // denominator and numerator of y
    logic                  q1_valid_reg;
    logic signed [D_W-1:0] q1_d_reg;
    logic signed [VH_W-1:0] q1_vh_reg;
    logic signed [UW-1:0]  q1_u_reg;
    logic                  q1_second_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q1_valid_reg <= 1'b0;
        else
            q1_valid_reg <= s_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        q1_d_reg      <= D_W'($signed({1'b0, focal_reg})) * D_W'($signed({1'b0, cos_reg}))
                         + D_W'(s_v_reg) * D_W'(sin_reg);
        q1_vh_reg     <= VH_W'(s_v_reg) * VH_W'($signed({1'b0, height_reg}));
        q1_u_reg      <= s_u_reg;
        q1_second_reg <= s_second_reg;
    end

    hlgp_pkg::pt_side_t d1_in_side;
    logic signed [N1_W-1:0] d1_num;

    always_comb
    begin
        d1_in_side.second = q1_second_reg;
        d1_in_side.deg    = (q1_d_reg <= D_W'(0)) || (cos_reg == '0) || (focal_reg == '0);
        d1_in_side.sat    = 1'b0;
        d1_in_side.u      = q1_u_reg;
        d1_in_side.y      = '0;
        d1_in_side.z      = '0;
        d1_num            = {q1_vh_reg, 14'd0};
    end

    logic                 d1_valid;
    logic signed [OW-1:0] d1_quot;
    logic                 d1_sat;
    hlgp_pkg::pt_side_t   d1_side;

    hlgp_div #(
        .NUM_W  (N1_W),
        .DEN_W  (VH_W),
        .SIDE_W (SIDE_W)
    ) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q1_valid_reg),
        .num       (d1_num),
        .den       (q1_d_reg[VH_W-1:0]),
        .in_side   (d1_in_side),
        .out_valid (d1_valid),
        .quot      (d1_quot),
        .sat       (d1_sat),
        .out_side  (d1_side)
    );

    // numerator of z
    logic                   q3_valid_reg;
    logic signed [N2_W-1:0] q3_num_reg;
    hlgp_pkg::pt_side_t     q3_side_reg;
    hlgp_pkg::pt_side_t     q3_side_next;

    always_comb
    begin
        q3_side_next     = d1_side;
        q3_side_next.sat = d1_side.sat || d1_sat;
        q3_side_next.y   = d1_quot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q3_valid_reg <= 1'b0;
        else
            q3_valid_reg <= d1_valid;
    end

    always_ff @(posedge clk)
    begin
        q3_num_reg  <= $signed(N2_W'({height_reg, 14'd0})) - N2_W'(d1_quot) * N2_W'(sin_reg);
        q3_side_reg <= q3_side_next;
    end

    logic                 d2_valid;
    logic signed [OW-1:0] d2_quot;
    logic                 d2_sat;
    hlgp_pkg::pt_side_t   d2_side;

    hlgp_div #(
        .NUM_W  (N2_W),
        .DEN_W  (15),
        .SIDE_W (SIDE_W)
    ) u_div_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q3_valid_reg),
        .num       (q3_num_reg),
        .den       (cos_reg),
        .in_side   (q3_side_reg),
        .out_valid (d2_valid),
        .quot      (d2_quot),
        .sat       (d2_sat),
        .out_side  (d2_side)
    );

    // numerator of x
    logic                   q4_valid_reg;
    logic signed [N3_W-1:0] q4_uz_reg;
    hlgp_pkg::pt_side_t     q4_side_reg;
    hlgp_pkg::pt_side_t     q4_side_next;

    always_comb
    begin
        q4_side_next     = d2_side;
        q4_side_next.sat = d2_side.sat || d2_sat;
        q4_side_next.z   = d2_quot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q4_valid_reg <= 1'b0;
        else
            q4_valid_reg <= d2_valid;
    end

    always_ff @(posedge clk)
    begin
        q4_uz_reg   <= N3_W'(d2_side.u) * N3_W'(d2_quot);
        q4_side_reg <= q4_side_next;
    end

    logic                 d3_valid;
    logic signed [OW-1:0] d3_quot;
    logic                 d3_sat;
    hlgp_pkg::pt_side_t   d3_side;

    hlgp_div #(
        .NUM_W  (N3_W),
        .DEN_W  (16),
        .SIDE_W (SIDE_W)
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q4_valid_reg),
        .num       (q4_uz_reg),
        .den       (focal_reg),
        .in_side   (q4_side_reg),
        .out_valid (d3_valid),
        .quot      (d3_quot),
        .sat       (d3_sat),
        .out_side  (d3_side)
    );

    // rotation products
    logic                  q5_valid_reg;
    logic signed [P_W-1:0] q5_p1_reg;
    logic signed [P_W-1:0] q5_p2_reg;
    logic signed [OW-1:0]  q5_x_reg;
    logic                  q5_sat_reg;
    logic                  q5_deg_reg;
    logic                  q5_second_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q5_valid_reg <= 1'b0;
        else
            q5_valid_reg <= d3_valid;
    end

    always_ff @(posedge clk)
    begin
        q5_p1_reg     <= P_W'($signed({1'b0, cos_reg})) * P_W'(d3_side.y);
        q5_p2_reg     <= P_W'(sin_reg) * P_W'(d3_side.z);
        q5_x_reg      <= d3_quot;
        q5_sat_reg    <= d3_side.sat || d3_sat;
        q5_deg_reg    <= d3_side.deg;
        q5_second_reg <= d3_side.second;
    end

    // round, add offset, clip; degenerate points give x zero and y at the maximum
    logic signed [G_W-1:0]   g_sum;
    logic signed [G_W-15:0]  g_rnd;
    logic signed [G_W-14:0]  g_off;
    logic signed [OW-1:0]    gx_next;
    logic signed [OW-1:0]    gy_next;
    logic                    sat_next;

    always_comb
    begin
        g_sum    = G_W'(q5_p2_reg) - G_W'(q5_p1_reg) + G_W'(8192);
        g_rnd    = g_sum[G_W-1:14];
        g_off    = (G_W-13)'(g_rnd) + (G_W-13)'(offset_reg);
        gx_next  = q5_x_reg;
        sat_next = q5_sat_reg;
        if (g_off > (G_W-13)'(hlgp_pkg::OUT_MAX))
        begin
            gy_next  = hlgp_pkg::OUT_MAX;
            sat_next = 1'b1;
        end
        else if (g_off < (G_W-13)'(hlgp_pkg::OUT_MIN))
        begin
            gy_next  = hlgp_pkg::OUT_MIN;
            sat_next = 1'b1;
        end
        else
            gy_next = g_off[OW-1:0];
        if (q5_deg_reg)
        begin
            gx_next  = '0;
            gy_next  = hlgp_pkg::OUT_MAX;
            sat_next = 1'b1;
        end
    end

    logic                 out_valid_reg;
    logic signed [OW-1:0] out_x_reg;
    logic signed [OW-1:0] out_y_reg;
    logic                 out_second_reg;
    logic                 out_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= q5_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        out_x_reg      <= gx_next;
        out_y_reg      <= gy_next;
        out_second_reg <= q5_second_reg;
        out_sat_reg    <= sat_next;
    end

    assign result_valid = out_valid_reg;
    assign ground_x     = out_x_reg;
    assign ground_y     = out_y_reg;
    assign second_point = out_second_reg;
    assign saturated    = out_sat_reg;

endmodule

FILE: bench/tb_hough_line_ground_projection_unit.sv
// ----------------------------------------------------------------------------
// tb_hough_line_ground_projection_unit
// Self-checking bench for the Hough line ground projection unit. Lines go in
// through the start/busy handshake from a queue. Each accepted line is
// predicted into two ground points, and every result strobe is checked in
// order against them. The run steps through several register settings,
// including extremes and degenerate ones, and idles the sender in random
// bursts.
// ----------------------------------------------------------------------------
module tb_hough_line_ground_projection_unit;

    typedef struct {
        logic signed [15:0] rho;
        logic signed [15:0] theta;
    } line_t;

    typedef struct {
        logic signed [19:0] gx;
        logic signed [19:0] gy;
        logic               second;
        logic               sat;
    } ground_pt_t;

    localparam longint ATAN_Q20 [16] = '{
        823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
        4096, 2048, 1024, 512, 256, 128, 64, 32
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic signed [15:0] line_distance = '0;
    logic signed [15:0] line_angle = '0;
    logic               cfg_valid = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;
    logic               busy;
    logic               cfg_ready;
    logic               result_valid;
    logic signed [19:0] ground_x;
    logic signed [19:0] ground_y;
    logic               second_point;
    logic               saturated;

    logic [11:0]        half_width;
    logic [11:0]        half_height;
    logic [15:0]        focal_length;
    logic [14:0]        camera_height;
    logic signed [15:0] ground_offset;
    logic signed [15:0] sin_tilt;
    logic [14:0]        cos_tilt;

    line_t      line_q [$];
    ground_pt_t ground_q [$];
    int         gap_cnt = 0;
    bit         calm = 1'b0;
    int         err_cnt = 0;

    hough_line_ground_projection_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .line_distance (line_distance),
        .line_angle    (line_angle),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result_valid  (result_valid),
        .ground_x      (ground_x),
        .ground_y      (ground_y),
        .second_point  (second_point),
        .saturated     (saturated)
    );

    always #6 clk = ~clk;

    function automatic longint clamp(input longint v, input longint lo, input longint hi,
                                     inout bit flag);
        if (v > hi)
        begin
            flag = 1'b1;
            return hi;
        end
        if (v < lo)
        begin
            flag = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic void cordic_sin_cos(input longint th, output longint s,
                                           output longint c);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     neg;
        bit     unused;
        x = 636751;
        y = 0;
        neg = 1'b0;
        unused = 1'b0;
        if (th > 12868)
        begin
            th -= 25736;
            neg = 1'b1;
        end
        else if (th < -12868)
        begin
            th += 25736;
            neg = 1'b1;
        end
        z = th * 128;
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= ATAN_Q20[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += ATAN_Q20[i];
            end
        end
        c = clamp((x + 32) >>> 6, -16384, 16384, unused);
        s = clamp((y + 32) >>> 6, -16384, 16384, unused);
        if (neg)
        begin
            c = -c;
            s = -s;
        end
    endfunction

    function automatic ground_pt_t project_point(input longint u, input longint v,
                                                 input bit second);
        ground_pt_t p;
        longint     h;
        longint     f;
        longint     ct;
        longint     st;
        longint     d;
        longint     y;
        longint     z;
        longint     x;
        longint     g;
        bit         sat;
        h = longint'(camera_height);
        f = longint'(focal_length);
        ct = longint'(cos_tilt);
        st = longint'(sin_tilt);
        sat = 1'b0;
        p.second = second;
        d = f * ct + v * st;
        if (d <= 0 || ct == 0 || f == 0)
        begin
            p.gx = '0;
            p.gy = hlgp_pkg::OUT_MAX;
            p.sat = 1'b1;
            return p;
        end
        y = clamp((v * h * 16384) / d, -524288, 524287, sat);
        z = clamp((h * 16384 - y * st) / ct, -524288, 524287, sat);
        x = clamp((u * z) / f, -524288, 524287, sat);
        g = ((-ct * y + st * z + 8192) >>> 14) + longint'(ground_offset);
        g = clamp(g, -524288, 524287, sat);
        p.gx = x[19:0];
        p.gy = g[19:0];
        p.sat = sat;
        return p;
    endfunction

    function automatic void predict_ground_pair(input logic signed [15:0] rho,
                                                input logic signed [15:0] theta);
        longint s;
        longint c;
        longint x0;
        longint y0;
        longint ls;
        longint lc;
        longint cu;
        longint cv;
        longint sg;
        longint u;
        longint v;
        cordic_sin_cos(longint'(theta), s, c);
        x0 = c * longint'(rho);
        y0 = s * longint'(rho);
        ls = 200 * s * 16;
        lc = 200 * c * 16;
        cu = longint'(half_width) * 262144;
        cv = longint'(half_height) * 262144;
        for (int k = 0; k < 2; k++)
        begin
            sg = k ? 1 : -1;
            u = (x0 + sg * ls - cu + 8192) >>> 14;
            v = (y0 - sg * lc - cv + 8192) >>> 14;
            ground_q = {ground_q, project_point(u, v, k[0])};
        end
    endfunction

    // driver: advance the line queue, hold start until the transfer
    always @(posedge clk)
    begin
        line_t item;
        if (rst_n)
        begin
            if (start && !busy)
                predict_ground_pair(line_distance, line_angle);
            if (!start || !busy)
            begin
                if (gap_cnt > 0)
                begin
                    gap_cnt <= gap_cnt - 1;
                    start <= 1'b0;
                end
                else if (line_q.size() > 0)
                begin
                    item = line_q.pop_front();
                    line_distance <= item.rho;
                    line_angle <= item.theta;
                    start <= 1'b1;
                    if (!calm && $urandom_range(0, 3) == 0)
                        gap_cnt <= $urandom_range(1, 7);
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        ground_pt_t want;
        if (rst_n && result_valid)
        begin
            if (ground_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected result gx=%0d gy=%0d", ground_x, ground_y);
            end
            else
            begin
                want = ground_q.pop_front();
                if (ground_x !== want.gx || ground_y !== want.gy ||
                    second_point !== want.second || saturated !== want.sat)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("mismatch exp gx=%0d gy=%0d sec=%0b sat=%0b act gx=%0d gy=%0d sec=%0b sat=%0b",
                                 want.gx, want.gy, want.second, want.sat,
                                 ground_x, ground_y, second_point, saturated);
                end
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            hlgp_pkg::CFG_HALF_WIDTH:    half_width = data[11:0];
            hlgp_pkg::CFG_HALF_HEIGHT:   half_height = data[11:0];
            hlgp_pkg::CFG_FOCAL_LENGTH:  focal_length = data;
            hlgp_pkg::CFG_CAMERA_HEIGHT: camera_height = data[14:0];
            hlgp_pkg::CFG_GROUND_OFFSET: ground_offset = data;
            hlgp_pkg::CFG_SIN_TILT:      sin_tilt = data;
            hlgp_pkg::CFG_COS_TILT:      cos_tilt = data[14:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [15:0] hw, input logic [15:0] hh,
                             input logic [15:0] f, input logic [15:0] h,
                             input logic [15:0] off, input logic [15:0] st,
                             input logic [15:0] ct);
        @(posedge clk);
        write_reg(hlgp_pkg::CFG_HALF_WIDTH, hw);
        write_reg(hlgp_pkg::CFG_HALF_HEIGHT, hh);
        write_reg(hlgp_pkg::CFG_FOCAL_LENGTH, f);
        write_reg(hlgp_pkg::CFG_CAMERA_HEIGHT, h);
        write_reg(hlgp_pkg::CFG_GROUND_OFFSET, off);
        write_reg(hlgp_pkg::CFG_SIN_TILT, st);
        write_reg(hlgp_pkg::CFG_COS_TILT, ct);
        write_reg(3'd7, 16'hFFFF);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (line_q.size() > 0 || start || gap_cnt > 0 || ground_q.size() > 0)
            @(posedge clk);
        repeat (110) @(posedge clk);
    endtask

    task automatic push_line(input logic [15:0] rho, input logic [15:0] theta);
        line_t item;
        item.rho = rho;
        item.theta = theta;
        line_q = {line_q, item};
    endtask

    task automatic push_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 1))
                push_line(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)));
            else
                push_line(16'($urandom_range(0, 16000) - 8000),
                          16'($urandom_range(0, 51472) - 25736));
        end
    endtask

    task automatic random_config();
        write_all(16'($urandom_range(0, 2048)), 16'($urandom_range(0, 2048)),
                  16'($urandom_range(16, 65535)), 16'($urandom_range(1, 32767)),
                  16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 32768) - 16384),
                  16'($urandom_range(1, 16384)));
    endtask

    initial
    begin
        half_width = 12'd320;
        half_height = 12'd240;
        focal_length = 16'd5120;
        camera_height = 15'd1638;
        ground_offset = 16'sd1434;
        sin_tilt = 16'sd6924;
        cos_tilt = 15'd14849;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_line(16'sd0, 16'sd0);
        push_line(16'h7FFF, 16'sd0);
        push_line(16'h8000, 16'sd0);
        push_line(16'sd3200, 16'h7FFF);
        push_line(16'sd3200, 16'h8000);
        push_line(16'sd1600, 16'sd12868);
        push_line(16'sd1600, 16'sd12869);
        push_line(16'sd1600, -16'sd12868);
        push_line(16'sd1600, -16'sd12869);
        push_line(16'sd1600, 16'sd25736);
        push_line(16'sd1600, -16'sd25736);
        push_line(16'h7FFF, 16'h7FFF);
        push_line(16'h8000, 16'h8000);
        push_line(-16'sd4000, 16'sd6434);
        push_line(16'sd4000, -16'sd6434);
        push_line(16'hFFFF, 16'hFFFF);
        push_line(16'h5555, 16'hAAAA);
        push_line(16'hAAAA, 16'h5555);
        push_random(150);
        wait_idle();

        write_all(16'd0, 16'd0, 16'd16, 16'd1, 16'h8000, 16'hC000, 16'd1);
        push_random(100);
        wait_idle();
        write_all(16'd2048, 16'd2048, 16'd65535, 16'd32767, 16'h7FFF, 16'd16384, 16'd16384);
        push_random(100);
        wait_idle();
        write_all(16'd320, 16'd240, 16'd0, 16'd1638, 16'd0, 16'd6924, 16'd0);
        push_random(40);
        wait_idle();
        write_all(16'hFFFF, 16'hFFFF, 16'd5120, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h7FFF);
        push_random(60);
        wait_idle();
        for (int p = 0; p < 4; p++)
        begin
            random_config();
            push_random(110);
            wait_idle();
        end
        write_all(16'd320, 16'd240, 16'd5120, 16'd1638, 16'd1434, 16'd6924, 16'd14849);
        push_random(100);
        wait_idle();
        calm = 1'b1;
        random_config();
        push_random(100);
        wait_idle();

        if (err_cnt == 0 && ground_q.size() == 0)
            $display("PASS hough_line_ground_projection_unit");
        else
            $display("FAIL hough_line_ground_projection_unit");
        $finish;
    end

    initial
    begin
        #(12 * 1000000);
        $display("FAIL hough_line_ground_projection_unit");
        $finish;
    end

endmodule
